// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the held-note chord mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/hnfcm_pkg.sv =====
// Types, constants and chord functions of the held-note fifth chord mapper.
package hnfcm_pkg;

  localparam int HELD_ENTRIES = 8;
  localparam int CNT_W = $clog2(HELD_ENTRIES + 1);
  localparam int ADDR_W = (HELD_ENTRIES > 1) ? $clog2(HELD_ENTRIES) : 1;

  localparam logic [6:0] NOTE_MAX = 7'd127;
  localparam logic [7:0] FIFTH_STEP = 8'd7;

  localparam logic [1:0] MODE_NOTE_ON = 2'd0;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [1:0] MODE_RELEASE_ALL = 2'd2;
  localparam logic [1:0] MODE_SILENT_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] channel;
    logic [6:0] note;
    logic [6:0] velocity;
  } evt_t;

  typedef struct packed {
    logic       is_note_on;
    logic [3:0] out_channel;
    logic [6:0] out_note;
    logic [6:0] out_velocity;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [3:0] channel;
    logic [6:0] key_note;
    logic [1:0] output_count;
    logic [6:0] note0;
    logic [6:0] note1;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_OFF0,
    S_OFF1,
    S_ON0,
    S_ON1,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  // Move a white-key note up to the next black key (black keys stay), saturating at the top note.
  function automatic logic [6:0] snap_up(input logic [6:0] n);
    logic [14:0] prod;
    logic [3:0]  oct;
    logic [6:0]  base;
    logic [3:0]  pc;
    logic [1:0]  step;
    logic [7:0]  sum;
    prod = 15'(n) * 15'd171;
    oct  = prod[14:11];
    base = 7'(oct) * 7'd12;
    pc   = 4'(n - base);
    unique case (pc)
      4'd0, 4'd2, 4'd5, 4'd7, 4'd9: step = 2'd1;
      4'd4, 4'd11:                  step = 2'd2;
      default:                      step = 2'd0;
    endcase
    sum = {1'b0, n} + 8'(step);
    return (sum > 8'(NOTE_MAX)) ? NOTE_MAX : sum[6:0];
  endfunction

  // Transposed root, clamped to the note range.
  function automatic logic [6:0] chord_root(input logic [6:0] note,
                                            input logic signed [7:0] transpose);
    logic signed [8:0] sum;
    logic [6:0]        r;
    sum = $signed({2'b00, note}) + $signed({transpose[7], transpose});
    if (sum[8]) begin
      r = 7'd0;
    end else if (sum[7]) begin
      r = NOTE_MAX;
    end else begin
      r = sum[6:0];
    end
    return r;
  endfunction

  // Fifth above a root, clamped to the top note.
  function automatic logic [6:0] chord_fifth(input logic [6:0] root);
    logic [7:0] f;
    f = {1'b0, root} + FIFTH_STEP;
    return (f > 8'(NOTE_MAX)) ? NOTE_MAX : f[6:0];
  endfunction

endpackage

// ===== hw/rtl/hnfcm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module hnfcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [AW-1:0]           raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/held_note_fifth_chord_mapper.sv =====
// Top level of the held-note fifth chord mapper: sequencer around the entry table RAM.
//
//   channel | signals                         | moves
//   evt     | evt_valid evt_ready evt         | one note event request
//   msg     | msg_valid msg_ready msg         | one MIDI message request
//   cfg     | cfg_valid cfg_ready cfg_transpose | transpose register write
//
// Search reads each table entry (S_READ, RAM read) and compares it (S_CHECK); each message
// has its own emit state. Note-on: its search and at most four messages; note-off: its search,
// up to two messages, then a read and a write state per entry shifted down; release-all: a read,
// a compare and up to two messages per entry. The next request is accepted in S_IDLE.
// Reset empties the table at once and sets transpose to zero; no clearing pass.
// A stalled msg channel holds the sequencer in its message state.
module held_note_fifth_chord_mapper (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     evt_valid,
  output logic                     evt_ready,
  input  hnfcm_pkg::evt_t          evt,
  output logic                     msg_valid,
  input  logic                     msg_ready,
  output hnfcm_pkg::msg_t          msg,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic signed [7:0]        cfg_transpose
);

  hnfcm_pkg::state_t state, state_next;
  hnfcm_pkg::evt_t   req;
  hnfcm_pkg::entry_t ent, rd_entry, wr_entry;
  hnfcm_pkg::msg_t   emit_msg;

  logic signed [7:0]             transpose;
  logic [hnfcm_pkg::CNT_W-1:0]   idx, held_count;
  logic [hnfcm_pkg::CNT_W-1:0]   idx_inc, idx_inc2;
  logic                          found;
  logic [hnfcm_pkg::ADDR_W-1:0]  raddr, waddr;
  logic                          wen;
  logic [hnfcm_pkg::ENTRY_W-1:0] rd_bits;
  logic                          evt_go, emit_req, emit_go;
  logic                          more, match, off_done, two_notes;
  logic [6:0]                    root_note, fifth_note;

  assign evt_ready = (state == hnfcm_pkg::S_IDLE);
  assign evt_go    = evt_valid && evt_ready;
  assign cfg_ready = 1'b1;

  assign idx_inc  = idx + 1'b1;
  assign idx_inc2 = idx + 2'd2;
  assign more     = idx_inc < held_count;
  assign rd_entry = rd_bits;
  assign match    = (rd_entry.channel == req.channel) && (rd_entry.key_note == req.note);

  assign root_note  = hnfcm_pkg::snap_up(hnfcm_pkg::chord_root(req.note, transpose));
  assign fifth_note = hnfcm_pkg::snap_up(hnfcm_pkg::chord_fifth(
                        hnfcm_pkg::chord_root(req.note, transpose)));
  assign two_notes  = (fifth_note != root_note);

  assign emit_go  = emit_req && (!msg_valid || msg_ready);
  assign off_done = ((state == hnfcm_pkg::S_OFF0) && emit_go && (ent.output_count != 2'd2))
                 || ((state == hnfcm_pkg::S_OFF1) && emit_go);

  hnfcm_ram #(
    .WIDTH (hnfcm_pkg::ENTRY_W),
    .DEPTH (hnfcm_pkg::HELD_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wen),
    .waddr (waddr),
    .wdata (wr_entry),
    .raddr (raddr),
    .rdata (rd_bits)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      hnfcm_pkg::S_IDLE: begin
        if (evt_go) begin
          unique case (evt.mode)
            hnfcm_pkg::MODE_NOTE_ON:
              state_next = (held_count == '0) ? hnfcm_pkg::S_ON0 : hnfcm_pkg::S_READ;
            hnfcm_pkg::MODE_NOTE_OFF, hnfcm_pkg::MODE_RELEASE_ALL:
              state_next = (held_count == '0) ? hnfcm_pkg::S_IDLE : hnfcm_pkg::S_READ;
            default: state_next = hnfcm_pkg::S_IDLE;
          endcase
        end
      end
      hnfcm_pkg::S_READ: state_next = hnfcm_pkg::S_CHECK;
      hnfcm_pkg::S_CHECK: begin
        priority if (req.mode == hnfcm_pkg::MODE_RELEASE_ALL || match) begin
          state_next = hnfcm_pkg::S_OFF0;
        end else if (more) begin
          state_next = hnfcm_pkg::S_READ;
        end else if (req.mode == hnfcm_pkg::MODE_NOTE_ON &&
                     held_count != hnfcm_pkg::CNT_W'(hnfcm_pkg::HELD_ENTRIES)) begin
          state_next = hnfcm_pkg::S_ON0;
        end else begin
          state_next = hnfcm_pkg::S_IDLE;
        end
      end
      hnfcm_pkg::S_OFF0, hnfcm_pkg::S_OFF1: begin
        if (state == hnfcm_pkg::S_OFF0 && emit_go && ent.output_count == 2'd2) begin
          state_next = hnfcm_pkg::S_OFF1;
        end else if (off_done) begin
          priority if (req.mode == hnfcm_pkg::MODE_NOTE_ON) begin
            state_next = hnfcm_pkg::S_ON0;
          end else if (!more) begin
            state_next = hnfcm_pkg::S_IDLE;
          end else if (req.mode == hnfcm_pkg::MODE_NOTE_OFF) begin
            state_next = hnfcm_pkg::S_SHIFT_RD;
          end else begin
            state_next = hnfcm_pkg::S_READ;
          end
        end
      end
      hnfcm_pkg::S_ON0: begin
        if (emit_go) begin
          state_next = two_notes ? hnfcm_pkg::S_ON1 : hnfcm_pkg::S_IDLE;
        end
      end
      hnfcm_pkg::S_ON1: begin
        if (emit_go) begin
          state_next = hnfcm_pkg::S_IDLE;
        end
      end
      hnfcm_pkg::S_SHIFT_RD: state_next = hnfcm_pkg::S_SHIFT_WR;
      hnfcm_pkg::S_SHIFT_WR:
        state_next = (idx_inc2 < held_count) ? hnfcm_pkg::S_SHIFT_RD : hnfcm_pkg::S_IDLE;
      default: state_next = hnfcm_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: message to emit and RAM port controls.
  always_comb begin
    emit_req = 1'b0;
    emit_msg = '0;
    raddr    = idx[hnfcm_pkg::ADDR_W-1:0];
    waddr    = idx[hnfcm_pkg::ADDR_W-1:0];
    wen      = 1'b0;
    wr_entry = rd_entry;
    unique case (state)
      hnfcm_pkg::S_OFF0, hnfcm_pkg::S_OFF1: begin
        emit_req             = 1'b1;
        emit_msg.out_channel = ent.channel;
        emit_msg.out_note    = (state == hnfcm_pkg::S_OFF0) ? ent.note0 : ent.note1;
        if (req.mode == hnfcm_pkg::MODE_NOTE_ON) begin
          emit_msg.last = 1'b0;
        end else begin
          emit_msg.last = ((state == hnfcm_pkg::S_OFF1) || ent.output_count != 2'd2) &&
                          ((req.mode == hnfcm_pkg::MODE_NOTE_OFF) || !more);
        end
      end
      hnfcm_pkg::S_ON0, hnfcm_pkg::S_ON1: begin
        emit_req              = 1'b1;
        emit_msg.is_note_on   = 1'b1;
        emit_msg.out_channel  = req.channel;
        emit_msg.out_note     = (state == hnfcm_pkg::S_ON0) ? root_note : fifth_note;
        emit_msg.out_velocity = req.velocity;
        emit_msg.last         = (state == hnfcm_pkg::S_ON1) || !two_notes;
        wen                   = (state == hnfcm_pkg::S_ON0) && emit_go;
        wr_entry.channel      = req.channel;
        wr_entry.key_note     = req.note;
        wr_entry.output_count = two_notes ? 2'd2 : 2'd1;
        wr_entry.note0        = root_note;
        wr_entry.note1        = fifth_note;
      end
      hnfcm_pkg::S_SHIFT_RD: raddr = idx_inc[hnfcm_pkg::ADDR_W-1:0];
      hnfcm_pkg::S_SHIFT_WR: wen = 1'b1;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= hnfcm_pkg::S_IDLE;
      held_count <= '0;
      transpose  <= '0;
      msg_valid  <= 1'b0;
      idx        <= '0;
      found      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        transpose <= cfg_transpose;
      end
      if (emit_go) begin
        msg_valid <= 1'b1;
      end else if (msg_ready) begin
        msg_valid <= 1'b0;
      end
      unique case (state)
        hnfcm_pkg::S_IDLE: begin
          if (evt_go) begin
            idx   <= '0;
            found <= 1'b0;
            if (evt.mode == hnfcm_pkg::MODE_SILENT_CLEAR) begin
              held_count <= '0;
            end
          end
        end
        hnfcm_pkg::S_CHECK: begin
          if (req.mode != hnfcm_pkg::MODE_RELEASE_ALL) begin
            priority if (match) begin
              found <= 1'b1;
            end else if (more) begin
              idx <= idx_inc;
            end else begin
              idx <= held_count;
            end
          end
        end
        hnfcm_pkg::S_OFF0, hnfcm_pkg::S_OFF1: begin
          if (off_done) begin
            if (req.mode == hnfcm_pkg::MODE_RELEASE_ALL) begin
              if (more) begin
                idx <= idx_inc;
              end else begin
                held_count <= '0;
              end
            end else if (req.mode == hnfcm_pkg::MODE_NOTE_OFF && !more) begin
              held_count <= held_count - 1'b1;
            end
          end
        end
        hnfcm_pkg::S_ON0: begin
          if (emit_go && !found) begin
            held_count <= held_count + 1'b1;
          end
        end
        hnfcm_pkg::S_SHIFT_WR: begin
          idx <= idx_inc;
          if (!(idx_inc2 < held_count)) begin
            held_count <= held_count - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (evt_go) begin
      req <= evt;
    end
    if (state == hnfcm_pkg::S_CHECK) begin
      ent <= rd_entry;
    end
    if (emit_go) begin
      msg <= emit_msg;
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_bound, (held_count <= hnfcm_pkg::CNT_W'(hnfcm_pkg::HELD_ENTRIES)), "table count overflow")
  `ASSERT_IMPLIES(a_read_in_table, (state == hnfcm_pkg::S_READ), (idx < held_count), "read past table")
  `ASSERT_NEXT(a_last_ends_item, (emit_go && emit_msg.last), (state == hnfcm_pkg::S_IDLE || state == hnfcm_pkg::S_SHIFT_RD), "busy after last")
  `ASSERT_IMPLIES(a_grow_on_note_on, (held_count > $past(held_count)), (req.mode == hnfcm_pkg::MODE_NOTE_ON && held_count == $past(held_count) + 1'b1), "bad table growth")

endmodule
